// ===== rtl/tppw_pkg.sv =====
`timescale 1ns / 1ps

package tppw_pkg;

  localparam int unsigned COORD_W = 15;

  typedef logic [15:0] colour_t;

  localparam logic [7:0] PEN_DOWN_BYTE = 8'h81;
  localparam colour_t    RGB_RED       = 16'hF800;
  localparam colour_t    RGB_GREEN     = 16'h07E0;
  localparam colour_t    RGB_BLUE      = 16'h001F;
  localparam colour_t    RGB_BLACK     = 16'h0000;

  localparam int unsigned SW_BLUE  = 0;
  localparam int unsigned SW_GREEN = 1;
  localparam int unsigned SW_RED   = 2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [9:0] switches;
  } touch_in_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [18:0] pixel_index;
    colour_t     colour;
    logic        last;
  } pixel_write_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    colour_t            colour;
  } touch_point_t;

  typedef enum logic [4:0] {
    PH_WAIT = 5'b00001,
    PH_X_LO = 5'b00010,
    PH_X_HI = 5'b00100,
    PH_Y_LO = 5'b01000,
    PH_Y_HI = 5'b10000
  } phase_e;

endpackage

// ===== rtl/tppw_parser.sv =====
`timescale 1ns / 1ps

module tppw_parser
  import tppw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         in_valid_i,
  input  touch_in_t    in_data_i,
  output logic         point_valid_o,
  output touch_point_t point_o
);

  phase_e             phase_q, phase_d;
  logic [COORD_W-1:0] x_q, x_d;
  logic [7:0]         ylo_q, ylo_d;
  logic               point_valid_q;
  touch_point_t       point_q;
  logic               accept;
  logic               done;
  logic [COORD_W-1:0] y_full;
  colour_t            colour;

  assign accept = in_valid_i && en_i;
  assign y_full = {in_data_i.rx_byte, 7'b0} | COORD_W'(ylo_q);

  always_comb begin
    priority if (in_data_i.switches[SW_RED]) begin
      colour = RGB_RED;
    end else if (in_data_i.switches[SW_BLUE]) begin
      colour = RGB_BLUE;
    end else if (in_data_i.switches[SW_GREEN]) begin
      colour = RGB_GREEN;
    end else begin
      colour = RGB_BLACK;
    end
  end

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    ylo_d   = ylo_q;
    done    = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_X_LO: begin
          x_d     = COORD_W'(in_data_i.rx_byte);
          phase_d = PH_X_HI;
        end
        PH_X_HI: begin
          x_d     = x_q | {in_data_i.rx_byte, 7'b0};
          phase_d = PH_Y_LO;
        end
        PH_Y_LO: begin
          ylo_d   = in_data_i.rx_byte;
          phase_d = PH_Y_HI;
        end
        PH_Y_HI: begin
          done    = 1'b1;
          phase_d = PH_WAIT;
        end
        default: begin
          phase_d = (in_data_i.rx_byte == PEN_DOWN_BYTE) ? PH_X_LO : PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_WAIT;
      x_q           <= '0;
      ylo_q         <= '0;
      point_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      x_q     <= x_d;
      ylo_q   <= ylo_d;
      if (en_i) begin
        point_valid_q <= done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      point_q.x      <= x_q;
      point_q.y      <= y_full;
      point_q.colour <= colour;
    end
  end

  assign point_valid_o = point_valid_q;
  assign point_o       = point_q;

endmodule

// ===== rtl/tppw_scale.sv =====
`timescale 1ns / 1ps

module tppw_scale
  import tppw_pkg::*;
#(
  parameter int unsigned SCALE = 640,
  parameter int unsigned FULL  = 4095,
  parameter int unsigned Q_W   = COORD_W + $clog2(SCALE)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [COORD_W-1:0] coord_i,
  output logic [Q_W-1:0]     quot_o
);

  localparam int unsigned RW = Q_W + 1;
  localparam int unsigned PW = 2 * Q_W + 1;
  localparam int unsigned DW = $clog2(FULL + 1);
  localparam int unsigned MW = Q_W + DW;
  localparam longint unsigned RECIP_L = (64'd1 << Q_W) / FULL;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [Q_W-1:0] n1_q, n2_q, n3_q;
  logic [Q_W-1:0] q2_q, q3_q, q4_q;
  logic [Q_W-1:0] p3_q;
  logic [PW-1:0]  recip_prod;
  logic [MW-1:0]  back_prod;
  logic [Q_W-1:0] rem;

  assign recip_prod = PW'(n1_q) * PW'(RECIP);
  assign back_prod  = MW'(q2_q) * MW'(FULL);
  assign rem        = n3_q - p3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= Q_W'(coord_i) * Q_W'(SCALE);
      n2_q <= n1_q;
      q2_q <= recip_prod[2*Q_W-1:Q_W];
      n3_q <= n2_q;
      q3_q <= q2_q;
      p3_q <= Q_W'(back_prod);
      q4_q <= q3_q + Q_W'(rem >= Q_W'(FULL));
    end
  end

  assign quot_o = q4_q;

endmodule

// ===== rtl/tppw_brush.sv =====
`timescale 1ns / 1ps

module tppw_brush
  import tppw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  parameter int unsigned SX_W          = 25,
  parameter int unsigned SY_W          = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            touch_valid_i,
  output logic            touch_ready_o,
  input  logic [SX_W-1:0] sx_i,
  input  logic [SY_W-1:0] sy_i,
  input  colour_t         colour_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pixel_write_t    out_data_o
);

  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int unsigned IDX_W = COL_W + ROW_W + 1;

  logic [3:0]       mask_q, mask_d;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  colour_t          colour_q;
  logic             ov_q, ov_d;
  pixel_write_t     out_q;
  pixel_write_t     write_d;
  logic [3:0]       pick;
  logic [3:0]       mask_new;
  logic             emit;
  logic             single;
  logic             accept;
  logic             on_screen;
  logic             has_left;
  logic             has_below;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] index;

  assign on_screen = (sx_i < SX_W'(SCREEN_WIDTH)) && (sy_i < SY_W'(SCREEN_HEIGHT));
  assign has_left  = (sx_i != '0);
  assign has_below = (sy_i < SY_W'(SCREEN_HEIGHT - 1));
  assign mask_new  = on_screen ? {1'b1, has_below, has_left, has_left & has_below} : 4'b0;

  assign pick   = mask_q & (~mask_q + 4'd1);
  assign single = ((mask_q & (mask_q - 4'd1)) == 4'b0);
  assign emit   = (mask_q != 4'b0) && (!ov_q || out_ready_i);

  assign touch_ready_o = (mask_q == 4'b0) || (emit && single);
  assign accept        = touch_valid_i && touch_ready_o;

  assign col   = (pick[0] || pick[1]) ? col_q - COL_W'(1) : col_q;
  assign row   = (pick[0] || pick[2]) ? row_q + ROW_W'(1) : row_q;
  assign index = IDX_W'(col) + IDX_W'(SCREEN_WIDTH) * IDX_W'(row);

  always_comb begin
    write_d.pixel_x     = 10'(col);
    write_d.pixel_y     = 9'(row);
    write_d.pixel_index = 19'(index);
    write_d.colour      = colour_q;
    write_d.last        = pick[3];
  end

  always_comb begin
    mask_d = emit ? (mask_q & ~pick) : mask_q;
    if (accept) begin
      mask_d = mask_new;
    end
    ov_d = ov_q;
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 4'b0;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q    <= COL_W'(sx_i);
      row_q    <= ROW_W'(sy_i);
      colour_q <= colour_i;
    end
    if (emit) begin
      out_q <= write_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/touch_packet_to_pixel_writes.sv =====
`timescale 1ns / 1ps

// Turns touchscreen serial bytes into frame-buffer pixel writes.
// The input channel carries one received byte per transaction, with the slide
// switch levels alongside; the switches are sampled on the byte that completes
// a packet. A packet is the pen-down byte followed by four coordinate bytes.
// The output channel carries one pixel write per transaction: column, row,
// frame-buffer index, RGB565 colour and a last flag on the final write of a touch.
// A byte can be accepted in every cycle while input ready is high. The
// completing byte runs through a four-stage scaling pipeline (a constant
// multiply, then a reciprocal division with one correction step) and then the
// brush stage, whose output register issues a touch's writes one per cycle
// while the receiver does not stall, up to four writes per touch.
// Off-screen touches and brush pixels produce no writes.
// When the receiver stalls, the output register holds its write; once a touch
// waits at the end of the scaling pipeline, the parser and the pipeline hold
// and input ready falls until the brush stage takes that touch.
// Reset returns the packet parser to waiting for a pen-down byte and empties the
// pipeline and the output register.

module touch_packet_to_pixel_writes
  import tppw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH     = 640,
  parameter int unsigned SCREEN_HEIGHT    = 480,
  parameter int unsigned TOUCH_FULL_SCALE = 4095
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  touch_in_t    in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output pixel_write_t out_data_o
);

  localparam int unsigned SX_W = COORD_W + $clog2(SCREEN_WIDTH);
  localparam int unsigned SY_W = COORD_W + $clog2(SCREEN_HEIGHT);

  logic         en;
  logic         point_valid;
  touch_point_t point;
  logic [3:0]   valid_q;
  colour_t      colour_q [4];
  logic [SX_W-1:0] sx;
  logic [SY_W-1:0] sy;
  logic         brush_ready;

  assign en         = !valid_q[3] || brush_ready;
  assign in_ready_o = en;

  tppw_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .point_valid_o (point_valid),
    .point_o       (point)
  );

  tppw_scale #(
    .SCALE (SCREEN_WIDTH),
    .FULL  (TOUCH_FULL_SCALE),
    .Q_W   (SX_W)
  ) u_scale_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (point.x),
    .quot_o  (sx)
  );

  tppw_scale #(
    .SCALE (SCREEN_HEIGHT),
    .FULL  (TOUCH_FULL_SCALE),
    .Q_W   (SY_W)
  ) u_scale_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .coord_i (point.y),
    .quot_o  (sy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 4'b0;
    end else if (en) begin
      valid_q <= {valid_q[2:0], point_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      colour_q[0] <= point.colour;
      colour_q[1] <= colour_q[0];
      colour_q[2] <= colour_q[1];
      colour_q[3] <= colour_q[2];
    end
  end

  tppw_brush #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .SX_W          (SX_W),
    .SY_W          (SY_W)
  ) u_brush (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .touch_valid_i (valid_q[3]),
    .touch_ready_o (brush_ready),
    .sx_i          (sx),
    .sy_i          (sy),
    .colour_i      (colour_q[3]),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== rtl/tppw_checker.sv =====
`timescale 1ns / 1ps

module tppw_checker
  import tppw_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         out_valid_o,
  input logic         out_ready_i,
  input pixel_write_t out_data_o
);

  // A stalled write must be held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pixel write changed while stalled");

  // The writes of one touch follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a brush burst");

  // All writes of one touch share the colour sampled with the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> $stable(out_data_o.colour))
    else $error("colour changed inside a brush burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.colour == RGB_RED) ||
                    (out_data_o.colour == RGB_GREEN) ||
                    (out_data_o.colour == RGB_BLUE) ||
                    (out_data_o.colour == RGB_BLACK))
    else $error("unexpected colour");

endmodule

bind touch_packet_to_pixel_writes tppw_checker u_tppw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
